[sv/cau_pkg.sv]
// Shared constants, codes, item types and the saturation helper for the
// complex arithmetic unit. No dependencies.
package cau_pkg;

   // Operand format
   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 8;

   // Derived datapath widths
   localparam int PROD_W = 2 * DATA_WIDTH;                // one product
   localparam int SUM_W  = PROD_W + 1;                    // sum of two products
   localparam int MAG_W  = SUM_W;                         // magnitude before narrowing
   localparam int QUO_W  = DATA_WIDTH + 1;                // quotient bits kept
   localparam int REM_W  = SUM_W + FRAC_BITS + QUO_W;     // divider partial remainder
   localparam int ROOT_W = DATA_WIDTH;                    // square root bits

   // Decoupling queue
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH) + 1;

   // Operation codes on the request channel
   localparam logic [2:0] FUNC_ADD = 3'd0;
   localparam logic [2:0] FUNC_SUB = 3'd1;
   localparam logic [2:0] FUNC_MUL = 3'd2;
   localparam logic [2:0] FUNC_DIV = 3'd3;
   localparam logic [2:0] FUNC_MOD = 3'd4;

   // Internal operation class set by the front end
   localparam logic [2:0] K_ADD  = 3'd0;
   localparam logic [2:0] K_SUB  = 3'd1;
   localparam logic [2:0] K_MUL  = 3'd2;
   localparam logic [2:0] K_DIV  = 3'd3;
   localparam logic [2:0] K_MOD  = 3'd4;
   localparam logic [2:0] K_DZ   = 3'd5;  // divide with a zero divisor
   localparam logic [2:0] K_NONE = 3'd6;  // unused operation code

   // Status codes
   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_SAT = 2'd1;
   localparam logic [1:0] ST_DZ  = 2'd2;

   // Classified item held in the queue
   typedef struct packed {
      logic [2:0]                   kind;
      logic signed [DATA_WIDTH-1:0] a_re;
      logic signed [DATA_WIDTH-1:0] a_im;
      logic signed [DATA_WIDTH-1:0] b_re;
      logic signed [DATA_WIDTH-1:0] b_im;
   } cau_item_type;

   // Write side of the queue
   typedef struct packed {
      logic         vld;
      cau_item_type item;
   } cau_push_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] val;
      logic                  sat;
   } cau_narrow_type;

   // Saturate a sign/magnitude value to DATA_WIDTH bits
   function automatic cau_narrow_type cau_narrow(input logic neg, input logic ovf,
                                                 input logic [MAG_W-1:0] mag);
      cau_narrow_type        r;
      logic [DATA_WIDTH-1:0] low;
      logic [MAG_W-1:0]      half;
      half  = MAG_W'(1) << (DATA_WIDTH - 1);
      low   = mag[DATA_WIDTH-1:0];
      r.sat = 1'b0;
      if (ovf) begin
         r.sat = 1'b1;
         r.val = neg ? DATA_WIDTH'(half) : DATA_WIDTH'(half - MAG_W'(1));
      end else if (!neg || mag == '0) begin
         if (mag > half - MAG_W'(1)) begin
            r.sat = 1'b1;
            r.val = DATA_WIDTH'(half - MAG_W'(1));
         end else begin
            r.val = low;
         end
      end else begin
         if (mag > half) begin
            r.sat = 1'b1;
            r.val = DATA_WIDTH'(half);
         end else begin
            r.val = (~low) + DATA_WIDTH'(1);
         end
      end
      return r;
   endfunction

endpackage

[sv/cau_req_if.sv]
// Request channel of the complex arithmetic unit: valid/ready and operands.
// Depends on cau_pkg.
interface cau_req_if;
   import cau_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [2:0]             func;
   logic signed [DATA_WIDTH-1:0] a_re;
   logic signed [DATA_WIDTH-1:0] a_im;
   logic signed [DATA_WIDTH-1:0] b_re;
   logic signed [DATA_WIDTH-1:0] b_im;

   modport source (output valid, func, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

[sv/cau_rsp_if.sv]
// Response channel of the complex arithmetic unit: valid/ready and result.
// Depends on cau_pkg.
interface cau_rsp_if;
   import cau_pkg::*;

   logic                   valid;
   logic                   ready;
   logic signed [DATA_WIDTH-1:0] res_re;
   logic signed [DATA_WIDTH-1:0] res_im;
   logic [1:0]             status;

   modport source (output valid, res_re, res_im, status, input ready);
   modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

[sv/cau_front.sv]
// Front end: accepts request items and classifies the operation.
// Depends on cau_pkg and cau_req_if.
module cau_front (
   cau_req_if.sink             req_chan,
   input  logic                q_full,
   output cau_pkg::cau_push_type push
);
   import cau_pkg::*;

   logic div_zero;

   // Take an item whenever the queue has room
   assign req_chan.ready = !q_full;
   assign div_zero = (req_chan.b_re == '0) && (req_chan.b_im == '0);

   // Classify the item
   always_comb begin
      push.vld       = req_chan.valid && !q_full;
      push.item.a_re = req_chan.a_re;
      push.item.a_im = req_chan.a_im;
      push.item.b_re = req_chan.b_re;
      push.item.b_im = req_chan.b_im;
      case (req_chan.func)
         FUNC_ADD: push.item.kind = K_ADD;
         FUNC_SUB: push.item.kind = K_SUB;
         FUNC_MUL: push.item.kind = K_MUL;
         FUNC_DIV: push.item.kind = div_zero ? K_DZ : K_DIV;
         FUNC_MOD: push.item.kind = K_MOD;
         default:  push.item.kind = K_NONE;
      endcase
   end
endmodule

[sv/cau_queue.sv]
// Short queue between front end and back end.
// Depends on cau_pkg.
module cau_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  cau_pkg::cau_push_type push,
   input  logic                  pop,
   output logic                  full,
   output logic                  head_vld,
   output cau_pkg::cau_item_type head
);
   import cau_pkg::*;

   cau_item_type     mem_ff [0:QUEUE_DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;

   // Full when pointers differ only in the wrap bit
   assign full = (wr_ptr_ff[PTR_W-1] != rd_ptr_ff[PTR_W-1]) &&
                 (wr_ptr_ff[PTR_W-2:0] == rd_ptr_ff[PTR_W-2:0]);
   assign head_vld = (wr_ptr_ff != rd_ptr_ff);
   assign head     = mem_ff[rd_ptr_ff[PTR_W-2:0]];

   assign wr_ptr_in = push.vld ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop      ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;

   // Pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push.vld) begin
         mem_ff[wr_ptr_ff[PTR_W-2:0]] <= push.item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.vld |-> !full) else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_vld) else $error("queue read while empty");
   a_full_has_head: assert property (@(posedge clock) disable iff (reset)
      full |-> head_vld) else $error("queue full but no head item");
endmodule

[sv/cau_back.sv]
// Back end: multiplier stage, combine stage, bit-per-stage divider and
// square root pipeline, then saturation into the response register.
// Depends on cau_pkg and cau_rsp_if.
module cau_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_vld,
   input  cau_pkg::cau_item_type head,
   output logic                  pop,
   cau_rsp_if.source             rsp_chan
);
   import cau_pkg::*;

   typedef struct packed {
      logic [2:0]        kind;
      logic              re_neg;
      logic              im_neg;
      logic              ovf_re;
      logic              ovf_im;
      logic [REM_W-1:0]  rem_re;
      logic [REM_W-1:0]  rem_im;
      logic [QUO_W-1:0]  q_re;
      logic [QUO_W-1:0]  q_im;
      logic [PROD_W-1:0] rad;   // divisor, or square root remainder
      logic [ROOT_W-1:0] root;
   } cau_stage_type;

   logic advance;

   // Multiplier stage
   logic                         s1_vld_ff;
   logic [2:0]                   s1_kind_ff;
   logic signed [PROD_W-1:0]     p_ff [0:5];
   logic signed [PROD_W-1:0]     p_in [0:5];
   logic signed [DATA_WIDTH:0]   as_re_ff, as_re_in;
   logic signed [DATA_WIDTH:0]   as_im_ff, as_im_in;
   logic signed [DATA_WIDTH-1:0] sq_x, sq_y;

   // Combine and divide/root stages
   logic          vld_ff [0:QUO_W];
   cau_stage_type stg_ff [0:QUO_W];
   cau_stage_type stg_in [0:QUO_W];
   logic signed [SUM_W-1:0] sre, sim;
   logic [MAG_W-1:0]        mre, mim;

   // Response register
   logic                  out_vld_ff;
   logic [DATA_WIDTH-1:0] res_re_ff, res_re_in;
   logic [DATA_WIDTH-1:0] res_im_ff, res_im_in;
   logic [1:0]            status_ff, status_in;
   cau_narrow_type        nre, nim;
   logic [MAG_W-1:0]      fre, fim;
   logic                  fovf_re, fovf_im;

   // Whole pipeline moves when the response register can be refilled
   assign advance = !out_vld_ff || rsp_chan.ready;
   assign pop     = advance && head_vld;

   // Products and add/subtract
   assign sq_x  = (head.kind == K_MOD) ? head.a_re : head.b_re;
   assign sq_y  = (head.kind == K_MOD) ? head.a_im : head.b_im;
   assign p_in[0] = PROD_W'(head.a_re) * PROD_W'(head.b_re);
   assign p_in[1] = PROD_W'(head.a_im) * PROD_W'(head.b_im);
   assign p_in[2] = PROD_W'(head.a_re) * PROD_W'(head.b_im);
   assign p_in[3] = PROD_W'(head.a_im) * PROD_W'(head.b_re);
   assign p_in[4] = PROD_W'(sq_x) * PROD_W'(sq_x);
   assign p_in[5] = PROD_W'(sq_y) * PROD_W'(sq_y);
   assign as_re_in = (head.kind == K_SUB) ?
                     (DATA_WIDTH + 1)'(head.a_re) - (DATA_WIDTH + 1)'(head.b_re) :
                     (DATA_WIDTH + 1)'(head.a_re) + (DATA_WIDTH + 1)'(head.b_re);
   assign as_im_in = (head.kind == K_SUB) ?
                     (DATA_WIDTH + 1)'(head.a_im) - (DATA_WIDTH + 1)'(head.b_im) :
                     (DATA_WIDTH + 1)'(head.a_im) + (DATA_WIDTH + 1)'(head.b_im);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= head_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_kind_ff <= head.kind;
         p_ff       <= p_in;
         as_re_ff   <= as_re_in;
         as_im_ff   <= as_im_in;
      end
   end

   // Combine products into signed sums per operation
   always_comb begin
      case (s1_kind_ff)
         K_ADD, K_SUB: begin
            sre = SUM_W'(as_re_ff);
            sim = SUM_W'(as_im_ff);
         end
         K_MUL: begin
            sre = SUM_W'(p_ff[0]) - SUM_W'(p_ff[1]);
            sim = SUM_W'(p_ff[2]) + SUM_W'(p_ff[3]);
         end
         K_DIV: begin
            sre = SUM_W'(p_ff[0]) + SUM_W'(p_ff[1]);
            sim = SUM_W'(p_ff[3]) - SUM_W'(p_ff[2]);
         end
         default: begin
            sre = '0;
            sim = '0;
         end
      endcase
      mre = sre[SUM_W-1] ? MAG_W'(-sre) : MAG_W'(sre);
      mim = sim[SUM_W-1] ? MAG_W'(-sim) : MAG_W'(sim);
      if (s1_kind_ff == K_MUL) begin
         mre = mre >> FRAC_BITS;
         mim = mim >> FRAC_BITS;
      end
      stg_in[0].kind   = s1_kind_ff;
      stg_in[0].re_neg = sre[SUM_W-1];
      stg_in[0].im_neg = sim[SUM_W-1];
      stg_in[0].ovf_re = 1'b0;
      stg_in[0].ovf_im = 1'b0;
      stg_in[0].rem_re = (s1_kind_ff == K_DIV) ? REM_W'(mre) << FRAC_BITS : REM_W'(mre);
      stg_in[0].rem_im = (s1_kind_ff == K_DIV) ? REM_W'(mim) << FRAC_BITS : REM_W'(mim);
      stg_in[0].q_re   = '0;
      stg_in[0].q_im   = '0;
      stg_in[0].rad    = PROD_W'($unsigned(p_ff[4]) + $unsigned(p_ff[5]));
      stg_in[0].root   = '0;
   end

   // One quotient bit per stage and one root bit in each stage but the first, most significant first
   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int BIT = QUO_W - 1 - k;
      logic [REM_W-1:0]  lim, dsh;
      logic [PROD_W:0]   sqt;
      logic              take;

      assign lim = REM_W'(stg_ff[k].rad) << QUO_W;
      assign dsh = REM_W'(stg_ff[k].rad) << BIT;

      if (BIT < ROOT_W) begin : g_root
         assign sqt  = ((PROD_W + 1)'(stg_ff[k].root) << (BIT + 1)) +
                       ((PROD_W + 1)'(1) << (2 * BIT));
         assign take = (stg_ff[k].kind == K_MOD) && ({1'b0, stg_ff[k].rad} >= sqt);
      end else begin : g_noroot
         assign sqt  = '0;
         assign take = 1'b0;
      end

      always_comb begin
         stg_in[k+1] = stg_ff[k];
         if (stg_ff[k].kind == K_DIV) begin
            // quotient too large for the output range
            if (k == 0) begin
               stg_in[k+1].ovf_re = stg_ff[k].rem_re >= lim;
               stg_in[k+1].ovf_im = stg_ff[k].rem_im >= lim;
            end
            if (!stg_in[k+1].ovf_re && stg_ff[k].rem_re >= dsh) begin
               stg_in[k+1].rem_re    = stg_ff[k].rem_re - dsh;
               stg_in[k+1].q_re[BIT] = 1'b1;
            end
            if (!stg_in[k+1].ovf_im && stg_ff[k].rem_im >= dsh) begin
               stg_in[k+1].rem_im    = stg_ff[k].rem_im - dsh;
               stg_in[k+1].q_im[BIT] = 1'b1;
            end
         end
         if (take) begin
            stg_in[k+1].rad  = PROD_W'({1'b0, stg_ff[k].rad} - sqt);
            stg_in[k+1].root = stg_ff[k].root | (ROOT_W'(1) << BIT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QUO_W; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= s1_vld_ff;
         for (int i = 1; i <= QUO_W; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stg_ff <= stg_in;
      end
   end

   // Select final magnitudes and saturate
   always_comb begin
      fre     = MAG_W'(stg_ff[QUO_W].rem_re);
      fim     = MAG_W'(stg_ff[QUO_W].rem_im);
      fovf_re = 1'b0;
      fovf_im = 1'b0;
      case (stg_ff[QUO_W].kind)
         K_DIV: begin
            fre     = MAG_W'(stg_ff[QUO_W].q_re);
            fim     = MAG_W'(stg_ff[QUO_W].q_im);
            fovf_re = stg_ff[QUO_W].ovf_re;
            fovf_im = stg_ff[QUO_W].ovf_im;
         end
         K_MOD: begin
            fre = MAG_W'(stg_ff[QUO_W].root);
            fim = '0;
         end
         K_DZ, K_NONE: begin
            fre = '0;
            fim = '0;
         end
         default: begin
         end
      endcase
      nre = cau_narrow(stg_ff[QUO_W].re_neg && stg_ff[QUO_W].kind != K_MOD, fovf_re, fre);
      nim = cau_narrow(stg_ff[QUO_W].im_neg && stg_ff[QUO_W].kind != K_MOD, fovf_im, fim);
      res_re_in = nre.val;
      res_im_in = nim.val;
      if (stg_ff[QUO_W].kind == K_DZ) begin
         status_in = ST_DZ;
      end else if (nre.sat || nim.sat) begin
         status_in = ST_SAT;
      end else begin
         status_in = ST_OK;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= vld_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         status_ff <= status_in;
      end
   end

   assign rsp_chan.valid  = out_vld_ff;
   assign rsp_chan.res_re = res_re_ff;
   assign rsp_chan.res_im = res_im_ff;
   assign rsp_chan.status = status_ff;

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (status_ff == ST_OK || status_ff == ST_SAT || status_ff == ST_DZ))
      else $error("unknown status code");
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && status_ff == ST_DZ |-> res_re_ff == '0 && res_im_ff == '0)
      else $error("divide by zero result not zero");
   a_last_stage_out: assert property (@(posedge clock) disable iff (reset)
      advance && vld_ff[QUO_W] |=> out_vld_ff)
      else $error("item lost at response register");
endmodule

[sv/complex_arithmetic_unit.sv]
// Complex arithmetic unit: add, subtract, multiply, divide, modulus (Q8.8).
// Throughput: one item per cycle while responses are taken; the divider
// resolves one bit per pipeline stage (17 stages), the square root one bit
// in each stage but the first, and a 4-entry queue decouples the sides.
// Reset (synchronous, active high) empties the queue and all pipeline stages.
// Depends on cau_pkg, cau_req_if, cau_rsp_if, cau_front, cau_queue, cau_back.
module complex_arithmetic_unit (
   input  logic      clock,
   input  logic      reset,
   cau_req_if.sink   req_chan,
   cau_rsp_if.source rsp_chan
);
   import cau_pkg::*;

   cau_push_type push;
   cau_item_type head;
   logic         q_full;
   logic         head_vld;
   logic         pop;

   cau_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push)
   );

   cau_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .full     (q_full),
      .head_vld (head_vld),
      .head     (head)
   );

   cau_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_vld (head_vld),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );
endmodule
